@@ design/opdm_pkg.sv @@
// Package: constants and transaction types for the overlap pair deletion marker.
`default_nettype none

package opdm_pkg;

  localparam int MAX_ATOMS = 4096;
  localparam int IDX_W     = 12;
  localparam int SLOT_W    = $clog2(MAX_ATOMS);
  localparam int TAG_W     = 31;
  localparam int POS_W     = 32;
  localparam int CUTOFF_W  = 48;
  localparam int NEAR_W    = 24;   // |d| must stay below 2^NEAR_W
  localparam int SQ_W      = 2 * NEAR_W;
  localparam int SUM_W     = SQ_W + 2;

  localparam logic REQ_BEGIN    = 1'b0;
  localparam logic REQ_NEIGHBOR = 1'b1;

  typedef struct packed {
    logic                    req_type;
    logic [IDX_W-1:0]        atom_index;
    logic                    atom_owned;
    logic                    in_first_group;
    logic                    in_second_group;
    logic [TAG_W-1:0]        atom_tag;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic                    pair_weighted;
    logic                    last_neighbor;
  } opdm_in_t;

  typedef struct packed {
    logic [IDX_W-1:0] result_index;
    logic             delete_atom;
  } opdm_out_t;

endpackage

`default_nettype wire

@@ design/opdm_ram.sv @@
// Generic single-write, single-read RAM with registered, read-first output.
`default_nettype none

module opdm_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ design/overlap_pair_deletion_marker_core.sv @@
// Top level: overlap pair deletion marker over a streamed neighbour list.
// Takes one transaction per cycle while not stalled; an accepted transaction
// is registered in s1, and the result of one that finishes a central atom is
// registered at the output as it commits. The deletion-mark store is a
// 4096 x 1 RAM with one registered read per transaction (the neighbour's or
// new centre's mark) and one write port; the active centre's mark is held in
// a register. After reset a clearing pass writes zero to every mark, one
// entry per cycle, while in_stall stays high. Output back-pressure stalls the
// input only when the pending transaction itself produces a result.
`default_nettype none

module overlap_pair_deletion_marker_core import opdm_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_wr_en,
  input  wire logic [CUTOFF_W-1:0] cfg_wr_data,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire opdm_in_t            in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output opdm_out_t                out_data
);

  logic [CUTOFF_W-1:0] cutoff;
  logic                clr_busy;
  logic [SLOT_W-1:0]   clr_addr;

  opdm_in_t            s1;
  logic                s1_valid;
  logic                byp;

  logic [IDX_W-1:0]        center_index;
  logic signed [POS_W-1:0] center_x, center_y, center_z;
  logic [TAG_W-1:0]        center_tag;
  logic [1:0]              center_groups;
  logic                    center_done;
  logic                    center_marked;

  logic              rd_data;
  logic              ram_wr_en;
  logic [SLOT_W-1:0] ram_wr_addr;
  logic              ram_wr_data;

  logic accept, is_begin, active_nb, nmark, hit, tie_ok, far;
  logic s1_res, s1_go, commit, wr_hit, res_delete;
  logic signed [POS_W:0] dx, dy, dz;
  logic [POS_W:0]        ax, ay, az;
  logic [SQ_W-1:0]       sx, sy, sz;
  logic [SUM_W-1:0]      dist_sq;

  opdm_ram #(.WIDTH(1), .DEPTH(MAX_ATOMS)) u_marks (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (accept),
    .rd_addr (in_data.atom_index[SLOT_W-1:0]),
    .rd_data (rd_data)
  );

  // distance
  always_comb begin
    dx = $signed({center_x[POS_W-1], center_x}) - $signed({s1.pos_x[POS_W-1], s1.pos_x});
    dy = $signed({center_y[POS_W-1], center_y}) - $signed({s1.pos_y[POS_W-1], s1.pos_y});
    dz = $signed({center_z[POS_W-1], center_z}) - $signed({s1.pos_z[POS_W-1], s1.pos_z});
    ax = dx[POS_W] ? (POS_W+1)'(0) - dx : dx;
    ay = dy[POS_W] ? (POS_W+1)'(0) - dy : dy;
    az = dz[POS_W] ? (POS_W+1)'(0) - dz : dz;
    far = (ax[POS_W:NEAR_W] != '0) || (ay[POS_W:NEAR_W] != '0)
       || (az[POS_W:NEAR_W] != '0);
    sx = SQ_W'(ax[NEAR_W-1:0]) * SQ_W'(ax[NEAR_W-1:0]);
    sy = SQ_W'(ay[NEAR_W-1:0]) * SQ_W'(ay[NEAR_W-1:0]);
    sz = SQ_W'(az[NEAR_W-1:0]) * SQ_W'(az[NEAR_W-1:0]);
    dist_sq = SUM_W'(sx) + SUM_W'(sy) + SUM_W'(sz);
  end

  always_comb begin
    nmark     = rd_data | byp;
    is_begin  = (s1.req_type == REQ_BEGIN);
    active_nb = !is_begin && !center_done;
    tie_ok    = s1.atom_owned ? !nmark
              : (!(center_groups[1] && s1.in_first_group) || (center_tag <= s1.atom_tag));
    hit = center_groups[0] && s1.in_second_group && s1.pair_weighted && !far
       && (dist_sq < SUM_W'(cutoff)) && tie_ok;
    s1_res     = s1.last_neighbor && (is_begin || !center_done);
    s1_go      = !s1_res || !out_valid || !out_stall;
    commit     = s1_valid && s1_go;
    wr_hit     = commit && active_nb && !center_marked && hit;
    res_delete = is_begin ? nmark : (center_marked | wr_hit);
    in_stall   = clr_busy || (s1_valid && !s1_go);
    accept     = in_valid && !in_stall;

    ram_wr_en   = clr_busy || wr_hit;
    ram_wr_addr = clr_busy ? clr_addr : center_index[SLOT_W-1:0];
    ram_wr_data = !clr_busy;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      cutoff        <= '0;
      clr_busy      <= 1'b1;
      clr_addr      <= '0;
      s1_valid      <= 1'b0;
      center_done   <= 1'b1;
      center_marked <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cutoff <= cfg_wr_data;
      end
      if (clr_busy) begin
        clr_addr <= clr_addr + SLOT_W'(1);
        if (clr_addr == SLOT_W'(MAX_ATOMS - 1)) begin
          clr_busy <= 1'b0;
        end
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
      if (commit) begin
        if (is_begin) begin
          center_done   <= s1.last_neighbor;
          center_marked <= nmark;
        end else if (!center_done) begin
          if (wr_hit) begin
            center_marked <= 1'b1;
          end
          if (s1.last_neighbor) begin
            center_done <= 1'b1;
          end
        end
      end
      if (commit && s1_res) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1  <= in_data;
      byp <= wr_hit && (center_index[SLOT_W-1:0] == in_data.atom_index[SLOT_W-1:0]);
    end
    if (commit && is_begin) begin
      center_index  <= s1.atom_index;
      center_x      <= s1.pos_x;
      center_y      <= s1.pos_y;
      center_z      <= s1.pos_z;
      center_tag    <= s1.atom_tag;
      center_groups <= {s1.in_second_group, s1.in_first_group};
    end
    if (commit && s1_res) begin
      out_data.result_index <= is_begin ? s1.atom_index : center_index;
      out_data.delete_atom  <= res_delete;
    end
  end

endmodule

`default_nettype wire

@@ design/opdm_checker.sv @@
// Checker on the ports of the overlap pair deletion marker, with its bind.
`default_nettype none

module opdm_checker import opdm_pkg::*; (
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire opdm_in_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire opdm_out_t out_data
);

  logic acc;
  assign acc = in_valid && !in_stall;

  // clearing pass holds off input straight after reset
  a_clear_after_reset: assert property (@(posedge clk) rst |=> in_stall)
    else $error("input not stalled after reset");

  // once running, input is only stalled by a full output
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
      ($past(!in_stall) && !$past(rst) && !out_valid) |-> !in_stall)
    else $error("input stalled with empty output");

  // a begin transaction with no neighbours yields a result once the output is free
  a_begin_last_result: assert property (@(posedge clk) disable iff (rst)
      (acc && in_data.req_type == REQ_BEGIN && in_data.last_neighbor)
      ##1 (!out_valid || !out_stall) |=> out_valid)
    else $error("missing result for begin transaction");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
      (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind overlap_pair_deletion_marker_core opdm_checker u_opdm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
